### rtl/unsigned_to_decimal_ascii_unit_defines.svh
// ----------------------------------------------------------------------------
// unsigned to decimal ascii unit: assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef UNSIGNED_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_UNIT_DEFINES_SVH

// same-cycle implication
`define U2DA_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u2da assertion failed");

// next-cycle implication
`define U2DA_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u2da assertion failed");

`endif

### rtl/u2da_pkg.sv
// ----------------------------------------------------------------------------
// u2da_pkg
// types, constants and digit helpers for the decimal ascii converter
// ----------------------------------------------------------------------------
package u2da_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned PAD_W   = 3;
	localparam int unsigned CHAR_W  = 6;
	localparam int unsigned ACC_W   = 64;
	localparam int unsigned FRAC_W  = 57;
	localparam int unsigned PROD_W  = 63;

	localparam logic [30:0]     RECIP_MUL  = 31'd1441151881;
	localparam logic [PAD_W-1:0] PAIR_COUNT = 3'd5;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

	typedef logic [9:0][3:0] digits_t;

	typedef struct packed {
		digits_t    digits;
		logic [3:0] start;
	} u2da_entry_t;

	// pair (0..99) to tens and units, tens via reciprocal 205/2048
	function automatic logic [7:0] pair_to_bcd(input logic [6:0] pair);
		logic [6:0]  p;
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  units;
		p     = (pair > 7'd99) ? 7'd99 : pair;
		prod  = 15'(p) * 15'd205;
		tens  = prod[14:11];
		units = p - 7'(tens) * 7'd10;
		return {tens, units[3:0]};
	endfunction

endpackage

### rtl/unsigned_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// unsigned_to_decimal_ascii_unit
// 32-bit unsigned number to decimal ascii characters, most significant first
// ----------------------------------------------------------------------------
// channel  | direction | tdata                                 | tlast
// s_axis   | in        | [31:0] value, [34:32] pad_pairs       | -
// m_axis   | out       | [5:0] char_code                       | last character
//
// in the front a number goes through intake, the 32x31 reciprocal multiply,
// then five pair steps of the times-100 fraction update
// the back sends one character per cycle unless stalled, one to ten per number
// the queue lets the front convert the next number while the back still sends
// reset clears control only; an output stall holds the back and then the queue
// ----------------------------------------------------------------------------
module unsigned_to_decimal_ascii_unit import u2da_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // value, pad_pairs, zero fill
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // char_code, zero fill
	output logic       m_axis_tlast
);

	logic              f_valid;
	logic              f_ready;
	u2da_entry_t       f_entry;
	logic              q_valid;
	logic              q_ready;
	u2da_entry_t       q_entry;
	logic [CHAR_W-1:0] char_code;

	u2da_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.value     (s_axis_tdata[31:0]),
		.pad_pairs (s_axis_tdata[34:32]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_entry (f_entry)
	);

	u2da_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_entry  (f_entry),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_entry (q_entry)
	);

	u2da_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_ready  (q_ready),
		.in_entry  (q_entry),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (char_code),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, char_code};

endmodule

### rtl/u2da_front.sv
// ----------------------------------------------------------------------------
// u2da_front
// takes numbers, splits them into five decimal pairs and finds the first digit
// ----------------------------------------------------------------------------
module u2da_front import u2da_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [VALUE_W-1:0]  value,
	input  logic [PAD_W-1:0]    pad_pairs,
	output logic                out_valid,
	input  logic                out_ready,
	output u2da_entry_t         out_entry
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_PAIR = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	logic [1:0]         phase_q;
	logic [2:0]         slot_q;
	logic [VALUE_W-1:0] val_q;
	logic [PAD_W-1:0]   pad_q;
	logic [ACC_W-1:0]   acc_q;
	digits_t            digits_q;
	logic [3:0]         start_q;
	logic               found_q;

	logic [PROD_W-1:0]  prod;
	logic [FRAC_W-1:0]  frac;
	logic [ACC_W-1:0]   mul100;
	logic [6:0]         pair;
	logic [7:0]         bcd;
	logic               full_pair;
	logic               take;
	logic               accept;

	assign prod      = PROD_W'(val_q) * PROD_W'(RECIP_MUL);
	assign frac      = acc_q[FRAC_W-1:0];
	assign mul100    = (ACC_W'(frac) << 6) + (ACC_W'(frac) << 5) + (ACC_W'(frac) << 2);
	assign pair      = acc_q[ACC_W-1:FRAC_W];
	assign bcd       = pair_to_bcd(pair);
	assign full_pair = (pair > 7'd9) || (slot_q < pad_q);
	assign take      = !found_q && ((pair != 7'd0) || (slot_q < pad_q) || (slot_q == 3'd0));

	assign out_valid = (phase_q == PH_DONE);
	assign out_entry = '{digits: digits_q, start: start_q};
	assign in_ready  = (phase_q == PH_IDLE) || ((phase_q == PH_DONE) && out_ready);
	assign accept    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			slot_q  <= '0;
			found_q <= 1'b0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (accept) begin
						phase_q <= PH_MUL;
						found_q <= 1'b0;
					end
				end
				PH_MUL: begin
					phase_q <= PH_PAIR;
					slot_q  <= PAIR_COUNT - 3'd1;
				end
				PH_PAIR: begin
					if (take)
						found_q <= 1'b1;
					if (slot_q == 3'd0)
						phase_q <= PH_DONE;
					else
						slot_q <= slot_q - 3'd1;
				end
				PH_DONE: begin
					if (accept) begin
						phase_q <= PH_MUL;
						found_q <= 1'b0;
					end else if (out_ready) begin
						phase_q <= PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
			pad_q <= (pad_pairs > PAIR_COUNT) ? PAIR_COUNT : pad_pairs;
		end
		if (phase_q == PH_MUL)
			acc_q <= {1'b0, prod};
		if (phase_q == PH_PAIR) begin
			acc_q    <= mul100;
			digits_q <= {digits_q[7:0], bcd[7:4], bcd[3:0]};
			if (take)
				start_q <= {slot_q, 1'b0} + {3'b000, full_pair};
		end
	end

endmodule

### rtl/u2da_queue.sv
// ----------------------------------------------------------------------------
// u2da_queue
// short first-in first-out buffer between converter front and character back
// ----------------------------------------------------------------------------
module u2da_queue import u2da_pkg::*; #(
	parameter int unsigned DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  u2da_entry_t in_entry,
	output logic        out_valid,
	input  logic        out_ready,
	output u2da_entry_t out_entry
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	u2da_entry_t       store_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              pop;

	assign in_ready  = (count_q != FULL_CNT);
	assign out_valid = (count_q != '0);
	assign out_entry = store_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			store_q[wr_ptr_q] <= in_entry;
	end

endmodule

### rtl/u2da_back.sv
// ----------------------------------------------------------------------------
// u2da_back
// walks a number's digits, sends one ascii character per cycle unless stalled
// ----------------------------------------------------------------------------
`include "unsigned_to_decimal_ascii_unit_defines.svh"

module u2da_back import u2da_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  u2da_entry_t       in_entry,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic              out_last
);

	logic              active_q;
	logic [3:0]        idx_q;
	digits_t           digits_q;
	logic              valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              adv;
	logic              load;

	assign adv       = !valid_q || out_ready;
	assign in_ready  = !active_q || (adv && (idx_q == 4'd0));
	assign load      = in_valid && in_ready;
	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_q  <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (adv)
				valid_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
				idx_q    <= in_entry.start;
			end else if (adv && active_q) begin
				if (idx_q == 4'd0)
					active_q <= 1'b0;
				else
					idx_q <= idx_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && active_q) begin
			char_q <= ASCII_ZERO | CHAR_W'(digits_q[idx_q]);
			last_q <= (idx_q == 4'd0);
		end
		if (load)
			digits_q <= in_entry.digits;
	end

	`U2DA_ASSERT_NOW(a_idx_range, active_q, idx_q <= 4'd9)
	`U2DA_ASSERT_NOW(a_char_digit, valid_q, (char_q >= ASCII_ZERO) && (char_q <= ASCII_ZERO + 6'd9))
	`U2DA_ASSERT_NEXT(a_run_ends, adv && active_q && (idx_q == 4'd0) && !in_valid, !active_q)
	`U2DA_ASSERT_NEXT(a_last_ends_run, adv && active_q && (idx_q == 4'd0), valid_q && last_q)

endmodule
